// File: rtl/kvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and codes for the keyed variable table
// Item layouts for both channels, operation and status codes, and the
// broadcast bundle that the table row sends to every cell.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_DEL    = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [63:0]        key;
        logic signed [31:0] new_value;
        logic [3:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [3:0]         found_position;
        logic [4:0]         entry_count;
    } t_out_item;

    // Sent to every cell: compare side at accept, write side at execute.
    typedef struct packed {
        logic               capture;
        logic [63:0]        cmp_key;
        logic               exec;
        logic [1:0]         func;
        logic               any_hit;
        logic [63:0]        wr_key;
        logic signed [31:0] wr_value;
    } t_bcast;

endpackage

// File: rtl/kvt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_cell: one entry of the table row
// Holds one key and value, compares the key on accept, and on execute
// overwrites, appends or takes its upper neighbor's entry on delete.
// ----------------------------------------------------------------------------
module kvt_cell (
    input  logic               i_clk,
    input  kvt_pkg::t_bcast    i_bc,
    input  logic               i_live,
    input  logic               i_append,
    input  logic               i_below,
    input  logic [63:0]        i_nxt_key,
    input  logic signed [31:0] i_nxt_value,
    output logic               o_cmp,
    output logic               o_hit,
    output logic               o_below,
    output logic [63:0]        o_key,
    output logic signed [31:0] o_value
);

    logic               r_hit;
    logic [63:0]        r_key;
    logic signed [31:0] r_value;

    assign o_cmp   = i_live && (r_key == i_bc.cmp_key);
    assign o_hit   = r_hit;
    // hit here or in any lower cell
    assign o_below = i_below | r_hit;
    assign o_key   = r_key;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (i_bc.capture) begin
            r_hit <= o_cmp;
        end
        if (i_bc.exec) begin
            unique case (i_bc.func)
                kvt_pkg::FUNC_ADD: begin
                    if (r_hit) begin
                        r_value <= i_bc.wr_value;
                    end else if (!i_bc.any_hit && i_append) begin
                        r_key   <= i_bc.wr_key;
                        r_value <= i_bc.wr_value;
                    end
                end
                kvt_pkg::FUNC_DEL: begin
                    // shift down from the deleted entry upward
                    if (i_bc.any_hit && (i_below || r_hit)) begin
                        r_key   <= i_nxt_key;
                        r_value <= i_nxt_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/keyed_variable_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_variable_table: compacting key/value table in a row of cells
// Add/overwrite, delete with compaction, lookup by key, read by position.
// ----------------------------------------------------------------------------
// For each item, the accept edge compares the key in every cell at once and
// latches the hit bits, and the execute edge then applies the update
// (overwrite, append, or a one-place shift of all entries above a deleted
// one) and loads the result register. A new item is taken once the previous
// one has been executed; execution waits only while the previous result is
// still held in the output register. Entries live at positions 0 to count-1
// in insertion order; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module keyed_variable_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kvt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kvt_pkg::t_out_item o_out_item
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                r_busy;
    logic                r_out_valid;
    logic [CW-1:0]       r_count;
    logic                r_any_hit;
    kvt_pkg::t_in_item   r_req;
    kvt_pkg::t_out_item  r_out;

    logic [CW-1:0]       n_count;
    kvt_pkg::t_out_item  n_out;

    logic                w_accept;
    logic                w_exec;
    logic                w_cmp_any;
    kvt_pkg::t_bcast     w_bc;

    logic [TABLE_DEPTH-1:0]    w_cmp;
    logic [TABLE_DEPTH-1:0]    w_hit;
    logic [TABLE_DEPTH:0]      w_below;
    logic [63:0]               w_key   [TABLE_DEPTH];
    logic signed [31:0]        w_value [TABLE_DEPTH];

    logic [IW-1:0]       w_hit_pos;
    logic signed [31:0]  w_hit_value;
    logic signed [31:0]  w_sel_value;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_exec     = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_cmp_any   = |w_cmp;

    always_comb begin
        w_bc.capture  = w_accept;
        w_bc.cmp_key  = i_in_item.key;
        w_bc.exec     = w_exec;
        w_bc.func     = r_req.func;
        w_bc.any_hit  = r_any_hit;
        w_bc.wr_key   = r_req.key;
        w_bc.wr_value = r_req.new_value;
    end

    assign w_below[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [63:0]        w_nk;
        logic signed [31:0] w_nv;
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_nk = w_key[g];
            assign w_nv = w_value[g];
        end else begin : g_mid
            assign w_nk = w_key[g+1];
            assign w_nv = w_value[g+1];
        end
        kvt_cell u_cell (
            .i_clk       (i_clk),
            .i_bc        (w_bc),
            .i_live      (CW'(g) < r_count),
            .i_append    (CW'(g) == r_count),
            .i_below     (w_below[g]),
            .i_nxt_key   (w_nk),
            .i_nxt_value (w_nv),
            .o_cmp       (w_cmp[g]),
            .o_hit       (w_hit[g]),
            .o_below     (w_below[g+1]),
            .o_key       (w_key[g]),
            .o_value     (w_value[g])
        );
    end

    // hits are one-hot, so an OR over the row encodes them
    always_comb begin
        w_hit_pos   = '0;
        w_hit_value = '0;
        w_sel_value = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_hit[i]) begin
                w_hit_pos   = w_hit_pos | IW'(i);
                w_hit_value = w_hit_value | w_value[i];
            end
            if (i < 16 && r_req.position == 4'(i)) begin
                w_sel_value = w_sel_value | w_value[i];
            end
        end
    end

    always_comb begin
        n_count              = r_count;
        n_out.status         = kvt_pkg::ST_NOT_FOUND;
        n_out.read_value     = '0;
        n_out.found_position = '0;
        unique case (r_req.func)
            kvt_pkg::FUNC_ADD: begin
                if (r_any_hit) begin
                    n_out.status         = kvt_pkg::ST_OK;
                    n_out.found_position = 4'(w_hit_pos);
                end else if (r_count == CW'(TABLE_DEPTH)) begin
                    n_out.status = kvt_pkg::ST_FULL;
                end else begin
                    n_out.status         = kvt_pkg::ST_OK;
                    n_out.found_position = 4'(r_count);
                    n_count              = r_count + CW'(1);
                end
            end
            kvt_pkg::FUNC_DEL: begin
                if (r_any_hit) begin
                    n_out.status         = kvt_pkg::ST_OK;
                    n_out.found_position = 4'(w_hit_pos);
                    n_count              = r_count - CW'(1);
                end
            end
            kvt_pkg::FUNC_LOOKUP: begin
                if (r_any_hit) begin
                    n_out.status         = kvt_pkg::ST_OK;
                    n_out.read_value     = w_hit_value;
                    n_out.found_position = 4'(w_hit_pos);
                end
            end
            default: begin
                if (9'(r_req.position) < 9'(r_count)) begin
                    n_out.status         = kvt_pkg::ST_OK;
                    n_out.read_value     = w_sel_value;
                    n_out.found_position = r_req.position;
                end
            end
        endcase
        n_out.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= i_in_item;
            r_any_hit <= w_cmp_any;
        end
        if (w_exec) begin
            r_out <= n_out;
        end
    end

endmodule

// File: sim/tb_keyed_variable_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_variable_table: self-checking bench for the keyed variable table
// Drives add, delete, lookup and read items through the valid/stall input
// channel, mirrors the table contents in a local model to predict every
// reply, and compares each accepted reply field by field in arrival order.
// Directed tests cover the empty, full and compaction corners; random
// traffic over a small key pool then runs under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_keyed_variable_table;

    localparam int TB_DEPTH   = 16;
    localparam int POOL_SIZE  = 24;
    localparam int IDLE_LIMIT = 1000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    kvt_pkg::t_in_item  in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    kvt_pkg::t_out_item out_item;

    // local mirror of the table
    logic [63:0]        tbl_keys [TB_DEPTH];
    logic signed [31:0] tbl_vals [TB_DEPTH];
    int                 live_n = 0;

    kvt_pkg::t_out_item replies_q [$];
    logic [63:0]        key_pool [POOL_SIZE];
    int                 fail_count = 0;
    int                 snd_idle_pct = 0;
    int                 rcv_stall_pct = 0;
    int                 quiet_cycles = 0;

    keyed_variable_table #(
        .TABLE_DEPTH(TB_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one operation to the mirror and return the reply it must produce.
    function automatic kvt_pkg::t_out_item apply_table_op(input kvt_pkg::t_in_item it);
        kvt_pkg::t_out_item r;
        int                 hit;
        int                 i;
        r = '0;
        r.status = kvt_pkg::ST_NOT_FOUND;
        hit = -1;
        for (i = 0; i < live_n; i++) begin
            if (hit < 0 && tbl_keys[i] == it.key) begin
                hit = i;
            end
        end
        case (it.func)
            kvt_pkg::FUNC_ADD: begin
                if (hit >= 0) begin
                    tbl_vals[hit] = it.new_value;
                    r.status = kvt_pkg::ST_OK;
                    r.found_position = hit[3:0];
                end else if (live_n >= TB_DEPTH) begin
                    r.status = kvt_pkg::ST_FULL;
                end else begin
                    tbl_keys[live_n] = it.key;
                    tbl_vals[live_n] = it.new_value;
                    r.status = kvt_pkg::ST_OK;
                    r.found_position = live_n[3:0];
                    live_n++;
                end
            end
            kvt_pkg::FUNC_DEL: begin
                if (hit >= 0) begin
                    // close the gap: everything above moves down one place
                    for (i = hit; i + 1 < live_n; i++) begin
                        tbl_keys[i] = tbl_keys[i + 1];
                        tbl_vals[i] = tbl_vals[i + 1];
                    end
                    live_n--;
                    r.status = kvt_pkg::ST_OK;
                    r.found_position = hit[3:0];
                end
            end
            kvt_pkg::FUNC_LOOKUP: begin
                if (hit >= 0) begin
                    r.status = kvt_pkg::ST_OK;
                    r.read_value = tbl_vals[hit];
                    r.found_position = hit[3:0];
                end
            end
            default: begin
                if (int'(it.position) < live_n) begin
                    r.status = kvt_pkg::ST_OK;
                    r.read_value = tbl_vals[it.position];
                    r.found_position = it.position;
                end
            end
        endcase
        r.entry_count = live_n[4:0];
        return r;
    endfunction

    function automatic kvt_pkg::t_in_item mk_item(input logic [1:0] func,
                                                  input logic [63:0] key,
                                                  input logic signed [31:0] value,
                                                  input logic [3:0] pos);
        kvt_pkg::t_in_item it;
        it.func = func;
        it.key = key;
        it.new_value = value;
        it.position = pos;
        return it;
    endfunction

    // Caller sits at a falling edge; returns at the falling edge after accept.
    task automatic send_item(input kvt_pkg::t_in_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        replies_q.push_back(apply_table_op(it));
        @(negedge clk);
    endtask

    task automatic wait_replies_drained();
        in_valid = 1'b0;
        while (replies_q.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic test_empty_table();
        send_item(mk_item(kvt_pkg::FUNC_READ, key_pool[2], 32'sd5, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_LOOKUP, key_pool[0], 32'sd0, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_DEL, key_pool[1], 32'sd0, 4'd15));
    endtask

    task automatic test_add_and_overwrite();
        send_item(mk_item(kvt_pkg::FUNC_ADD, 64'd0, 32'sh8000_0000, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_ADD, '1, 32'sh7fff_ffff, 4'd15));
        send_item(mk_item(kvt_pkg::FUNC_ADD, 64'd0, -32'sd1, 4'd15));
        send_item(mk_item(kvt_pkg::FUNC_LOOKUP, '1, 32'sd0, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_READ, 64'd0, 32'sd0, 4'd1));
        send_item(mk_item(kvt_pkg::FUNC_READ, '1, '1, 4'd2));
    endtask

    task automatic test_full_table();
        int k;
        for (k = 2; k < TB_DEPTH; k++) begin
            send_item(mk_item(kvt_pkg::FUNC_ADD, key_pool[k], $urandom(),
                              4'($urandom_range(15))));
        end
        send_item(mk_item(kvt_pkg::FUNC_ADD, key_pool[TB_DEPTH], 32'sd77, 4'd0));
        // overwrite must still work with no free slot
        send_item(mk_item(kvt_pkg::FUNC_ADD, '1, 32'sd123, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_READ, 64'd0, 32'sd0, 4'd15));
    endtask

    task automatic test_delete_compaction();
        send_item(mk_item(kvt_pkg::FUNC_DEL, key_pool[7], 32'sd0, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_DEL, key_pool[TB_DEPTH - 1], 32'sd0, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_DEL, 64'd0, 32'sd0, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_LOOKUP, key_pool[7], 32'sd0, 4'd0));
        send_item(mk_item(kvt_pkg::FUNC_READ, 64'd0, 32'sd0, 4'd0));
    endtask

    // Mostly pool keys so that hits, overwrites and a full table are common.
    function automatic kvt_pkg::t_in_item random_table_op(input int add_pct);
        kvt_pkg::t_in_item it;
        int                roll;
        roll = $urandom_range(99);
        if (roll < add_pct) begin
            it.func = kvt_pkg::FUNC_ADD;
        end else if (roll < add_pct + (100 - add_pct) / 2) begin
            it.func = kvt_pkg::FUNC_DEL;
        end else begin
            it.func = $urandom_range(1) ? kvt_pkg::FUNC_LOOKUP : kvt_pkg::FUNC_READ;
        end
        if ($urandom_range(99) < 85) begin
            it.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            it.key = {$urandom(), $urandom()};
        end
        it.new_value = $urandom();
        it.position = 4'($urandom_range(15));
        return it;
    endfunction

    task automatic run_traffic_phase(input int snd_pct, input int rcv_pct, input int n_items,
                                     input bit pause_midway);
        int i;
        snd_idle_pct = snd_pct;
        rcv_stall_pct = rcv_pct;
        for (i = 0; i < n_items; i++) begin
            if (pause_midway && i == n_items / 2) begin
                wait_replies_drained();
            end
            // swing between filling and draining the table
            send_item(random_table_op(((i / 28) % 2) ? 35 : 60));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 105, 1'b0);
        run_traffic_phase(52, 0, 105, 1'b1);
        run_traffic_phase(0, 52, 105, 1'b0);
        run_traffic_phase(30, 30, 105, 1'b0);
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
    endtask

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge clk) begin : reply_check
        kvt_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (replies_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected reply, status %0d value %0d pos %0d count %0d",
                         $time, out_item.status, out_item.read_value,
                         out_item.found_position, out_item.entry_count);
            end else begin
                want = replies_q.pop_front();
                if (out_item.status !== want.status) begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_item.status);
                end
                if (out_item.read_value !== want.read_value) begin
                    fail_count++;
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.read_value, out_item.read_value);
                end
                if (out_item.found_position !== want.found_position) begin
                    fail_count++;
                    $display("%0t: found_position expected %0d actual %0d",
                             $time, want.found_position, out_item.found_position);
                end
                if (out_item.entry_count !== want.entry_count) begin
                    fail_count++;
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, out_item.entry_count);
                end
            end
        end
    end

    // End the run if neither channel moves an item for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : main
        int k;
        key_pool[0] = 64'd0;
        key_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) begin
            key_pool[k] = {$urandom(), $urandom()};
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_add_and_overwrite();
        test_full_table();
        test_delete_compaction();
        test_random_traffic();

        in_valid = 1'b0;
        while (replies_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: keyed_variable_table.f
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/keyed_variable_table.sv
sim/tb_keyed_variable_table.sv
